@@ hw/rtl/rational_fraction_alu_top_macros.svh @@
// assertion macros for the rational fraction alu
`ifndef RATIONAL_FRACTION_ALU_TOP_MACROS_SVH
`define RATIONAL_FRACTION_ALU_TOP_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define RFA_ASSERT_IMP(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("rfa check failed");

// next-cycle implication checked outside reset
`define RFA_ASSERT_NXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("rfa check failed");

`endif

@@ hw/rtl/rfa_pkg.sv @@
package rfa_pkg;

   localparam int WORD_BITS_DEF = 64;

   localparam logic [1:0] FUNC_ADD = 2'd0;
   localparam logic [1:0] FUNC_SUB = 2'd1;
   localparam logic [1:0] FUNC_MUL = 2'd2;
   localparam logic [1:0] FUNC_DIV = 2'd3;

   // shared unit operations
   localparam logic [1:0] UOP_GCD = 2'd0;
   localparam logic [1:0] UOP_DIV = 2'd1;
   localparam logic [1:0] UOP_MUL = 2'd2;

   typedef struct packed {
      logic       start;
      logic [1:0] op;
   } unit_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_sts_type;

endpackage

@@ hw/rtl/rational_fraction_alu_top.sv @@
// channel  dir  ports                         item
// req      in   req_tvalid/tready/tdata[263:0] func, a_num, a_den, b_num, b_den
// rsp      out  rsp_tvalid/tready/tdata[127:0] res_num, res_den; tuser overflow
//
// one item at a time through a shared gcd/divide/multiply unit, one bit a cycle
// a gcd runs one restoring division per euclid round until the remainder is zero
// req_tready is low from acceptance until the result is taken
// reset is synchronous and clears the sequencer and output valid
module rational_fraction_alu_top #(
   parameter int WORD_BITS = rfa_pkg::WORD_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [263:0] req_tdata,  // func[1:0], a_num, a_den, b_num, b_den, pad
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,  // res_num, res_den
   output logic         rsp_tuser   // overflow
);
   import rfa_pkg::*;

   unit_cmd_type         cmd;
   unit_sts_type         sts;
   logic [WORD_BITS-1:0] opa, opb, u_lo, u_hi;
   logic                 busy, fin, r_ov;
   logic [WORD_BITS-1:0] r_num, r_den;
   logic                 vld_ff, vld_in;
   logic [127:0]         dat_ff, dat_in;
   logic                 ov_ff, ov_in;
   logic                 start;

   assign req_tready = !busy && !vld_ff;
   assign start      = req_tvalid && req_tready;

   rfa_unit #(.WORD_BITS(WORD_BITS)) u_unit (
      .clock, .reset, .cmd, .opa, .opb, .sts, .res_lo(u_lo), .res_hi(u_hi)
   );

   rfa_seq #(.WORD_BITS(WORD_BITS)) u_seq (
      .clock, .reset, .start,
      .func  (req_tdata[1:0]),
      .a_num (req_tdata[2 +: WORD_BITS]),
      .a_den (req_tdata[66 +: WORD_BITS]),
      .b_num (req_tdata[130 +: WORD_BITS]),
      .b_den (req_tdata[194 +: WORD_BITS]),
      .cmd, .opa, .opb, .sts, .u_lo, .u_hi,
      .busy, .fin, .r_num, .r_den, .r_ov
   );

   always_comb begin
      vld_in = vld_ff;
      dat_in = dat_ff;
      ov_in  = ov_ff;
      if (rsp_tvalid && rsp_tready) vld_in = 1'b0;
      if (fin) begin
         vld_in = 1'b1;
         dat_in = {64'(r_den), 64'(signed'(r_num))};
         ov_in  = r_ov;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      dat_ff <= dat_in;
      ov_ff  <= ov_in;
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = dat_ff;
   assign rsp_tuser  = ov_ff;

endmodule

@@ hw/rtl/rfa_unit.sv @@
module rfa_unit #(
   parameter int WORD_BITS = rfa_pkg::WORD_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rfa_pkg::unit_cmd_type  cmd,
   input  logic [WORD_BITS-1:0]   opa,
   input  logic [WORD_BITS-1:0]   opb,
   output rfa_pkg::unit_sts_type  sts,
   output logic [WORD_BITS-1:0]   res_lo,
   output logic [WORD_BITS-1:0]   res_hi
);
   import rfa_pkg::*;

   localparam int CW = $clog2(WORD_BITS + 1);

   logic [1:0]           op_ff, op_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [WORD_BITS-1:0] x_ff, x_in;
   logic [WORD_BITS-1:0] y_ff, y_in;
   logic [WORD_BITS-1:0] acc_ff, acc_in;
   logic [WORD_BITS:0]   sub_w;
   logic [WORD_BITS:0]   add_w;
   logic [WORD_BITS-1:0] rem_sh;

   assign rem_sh = {acc_ff[WORD_BITS-2:0], x_ff[WORD_BITS-1]};
   assign sub_w  = {1'b0, rem_sh} - {1'b0, y_ff};
   assign add_w  = {1'b0, acc_ff} + {1'b0, (x_ff[0] ? y_ff : '0)};

   // gcd is euclid: each remainder is one restoring division (x mod y)
   always_comb begin
      op_in   = op_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      acc_in  = acc_ff;
      if (cmd.start && !busy_ff) begin
         op_in   = cmd.op;
         busy_in = 1'b1;
         x_in    = opa;
         y_in    = opb;
         acc_in  = '0;
         cnt_in  = CW'(WORD_BITS);
         if (cmd.op == UOP_GCD && opb == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            acc_in  = opa;
         end
      end else if (busy_ff) begin
         case (op_ff)
            UOP_MUL: begin
               x_in   = {add_w[0], x_ff[WORD_BITS-1:1]};
               acc_in = add_w[WORD_BITS:1];
               cnt_in = cnt_ff - 1'b1;
               if (cnt_ff == CW'(1)) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end
            end
            default: begin
               // restoring division step, quotient shifts into x
               if (acc_ff[WORD_BITS-1] || !sub_w[WORD_BITS]) begin
                  acc_in = sub_w[WORD_BITS-1:0];
                  x_in   = {x_ff[WORD_BITS-2:0], 1'b1};
               end else begin
                  acc_in = rem_sh;
                  x_in   = {x_ff[WORD_BITS-2:0], 1'b0};
               end
               cnt_in = cnt_ff - 1'b1;
               if (cnt_ff == CW'(1)) begin
                  if (op_ff == UOP_GCD) begin
                     if (acc_in == '0) begin
                        busy_in = 1'b0;
                        done_in = 1'b1;
                        acc_in  = y_ff;
                     end else begin
                        x_in   = y_ff;
                        y_in   = acc_in;
                        acc_in = '0;
                        cnt_in = CW'(WORD_BITS);
                     end
                  end else begin
                     busy_in = 1'b0;
                     done_in = 1'b1;
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         op_ff   <= UOP_GCD;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         op_ff   <= op_in;
         cnt_ff  <= cnt_in;
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      acc_ff <= acc_in;
   end

   // gcd: result in res_lo; div: quotient lo, remainder hi; mul: hi:lo
   always_comb begin
      case (op_ff)
         UOP_GCD: begin
            res_lo = acc_ff;
            res_hi = '0;
         end
         UOP_DIV: begin
            res_lo = x_ff;
            res_hi = acc_ff;
         end
         default: begin
            res_lo = x_ff;
            res_hi = acc_ff;
         end
      endcase
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;

endmodule

@@ hw/rtl/rfa_seq.sv @@
module rfa_seq #(
   parameter int WORD_BITS = rfa_pkg::WORD_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [1:0]             func,
   input  logic [WORD_BITS-1:0]   a_num,
   input  logic [WORD_BITS-1:0]   a_den,
   input  logic [WORD_BITS-1:0]   b_num,
   input  logic [WORD_BITS-1:0]   b_den,
   output rfa_pkg::unit_cmd_type  cmd,
   output logic [WORD_BITS-1:0]   opa,
   output logic [WORD_BITS-1:0]   opb,
   input  rfa_pkg::unit_sts_type  sts,
   input  logic [WORD_BITS-1:0]   u_lo,
   input  logic [WORD_BITS-1:0]   u_hi,
   output logic                   busy,
   output logic                   fin,
   output logic [WORD_BITS-1:0]   r_num,
   output logic [WORD_BITS-1:0]   r_den,
   output logic                   r_ov
);
   import rfa_pkg::*;

   localparam logic [WORD_BITS-1:0] HALF = {1'b1, {(WORD_BITS-1){1'b0}}};

   // step codes: each step but idle, fix, sum, split and done issues one unit op and waits for done
   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_RA_G  = 5'd1;  // gcd(am, ad)
   localparam logic [4:0] S_RA_N  = 5'd2;
   localparam logic [4:0] S_RA_D  = 5'd3;
   localparam logic [4:0] S_RB_G  = 5'd4;
   localparam logic [4:0] S_RB_N  = 5'd5;
   localparam logic [4:0] S_RB_D  = 5'd6;
   localparam logic [4:0] S_FIX   = 5'd7;  // zero-denominator, sign and reciprocal fixups
   localparam logic [4:0] S_AD_G  = 5'd8;  // gcd(ad, bd)
   localparam logic [4:0] S_AD_Q1 = 5'd9;  // bd / g
   localparam logic [4:0] S_AD_Q2 = 5'd10; // ad / g
   localparam logic [4:0] S_AD_M1 = 5'd11;
   localparam logic [4:0] S_AD_M2 = 5'd12;
   localparam logic [4:0] S_AD_M3 = 5'd13;
   localparam logic [4:0] S_AD_S  = 5'd14;
   localparam logic [4:0] S_MU_G1 = 5'd15;
   localparam logic [4:0] S_MU_G2 = 5'd16;
   localparam logic [4:0] S_MU_Q1 = 5'd17;
   localparam logic [4:0] S_MU_Q2 = 5'd18;
   localparam logic [4:0] S_MU_Q3 = 5'd19;
   localparam logic [4:0] S_MU_Q4 = 5'd20;
   localparam logic [4:0] S_MU_M1 = 5'd21;
   localparam logic [4:0] S_MU_M2 = 5'd22;
   localparam logic [4:0] S_SPLIT = 5'd23;
   localparam logic [4:0] S_RR_G  = 5'd24;
   localparam logic [4:0] S_RR_N  = 5'd25;
   localparam logic [4:0] S_RR_D  = 5'd26;
   localparam logic [4:0] S_DONE  = 5'd27;

   logic [4:0]           st_ff, st_in;
   logic                 iss_ff, iss_in;
   logic [1:0]           fn_ff, fn_in;
   logic                 an_ff, an_in, bn_ff, bn_in;
   logic [WORD_BITS-1:0] am_ff, am_in, ad_ff, ad_in;
   logic [WORD_BITS-1:0] bm_ff, bm_in, bd_ff, bd_in;
   logic [WORD_BITS-1:0] g_ff, g_in, g2_ff, g2_in;
   logic [WORD_BITS-1:0] t1_ff, t1_in, t2_ff, t2_in;
   logic                 ov_ff, ov_in;
   logic                 rn_ff, rn_in;
   logic [WORD_BITS-1:0] rm_ff, rm_in, rd_ff, rd_in;
   logic [WORD_BITS-1:0] gnz;
   logic [WORD_BITS-1:0] lim;
   logic [WORD_BITS-1:0] sum_w;
   logic [WORD_BITS-1:0] wr_val;
   logic                 wr_ov;
   logic                 neg_sel;

   assign gnz = (u_lo == '0) ? {{(WORD_BITS-1){1'b0}}, 1'b1} : u_lo;
   assign sum_w = t1_ff + t2_ff;

   // signed wrap of the product in unit result by sign neg_sel
   always_comb begin
      case (st_ff)
         S_AD_M1: neg_sel = an_ff;
         S_AD_M2: neg_sel = bn_ff;
         default: neg_sel = an_ff ^ bn_ff;
      endcase
      lim    = neg_sel ? HALF : HALF - 1'b1;
      wr_ov  = (u_hi != '0) || (u_lo > lim);
      wr_val = neg_sel ? ('0 - u_lo) : u_lo;
   end

   always_comb begin
      cmd.start = 1'b0;
      cmd.op    = UOP_GCD;
      opa       = '0;
      opb       = '0;
      case (st_ff)
         S_RA_G:  begin cmd.op = UOP_GCD; opa = am_ff; opb = ad_ff; end
         S_RA_N:  begin cmd.op = UOP_DIV; opa = am_ff; opb = g_ff; end
         S_RA_D:  begin cmd.op = UOP_DIV; opa = ad_ff; opb = g_ff; end
         S_RB_G:  begin cmd.op = UOP_GCD; opa = bm_ff; opb = bd_ff; end
         S_RB_N:  begin cmd.op = UOP_DIV; opa = bm_ff; opb = g_ff; end
         S_RB_D:  begin cmd.op = UOP_DIV; opa = bd_ff; opb = g_ff; end
         S_AD_G:  begin cmd.op = UOP_GCD; opa = ad_ff; opb = bd_ff; end
         S_AD_Q1: begin cmd.op = UOP_DIV; opa = bd_ff; opb = g_ff; end
         S_AD_Q2: begin cmd.op = UOP_DIV; opa = ad_ff; opb = g_ff; end
         S_AD_M1: begin cmd.op = UOP_MUL; opa = am_ff; opb = g2_ff; end
         S_AD_M2: begin cmd.op = UOP_MUL; opa = bm_ff; opb = ad_ff; end
         S_AD_M3: begin cmd.op = UOP_MUL; opa = ad_ff; opb = bd_ff; end
         S_MU_G1: begin cmd.op = UOP_GCD; opa = am_ff; opb = bd_ff; end
         S_MU_G2: begin cmd.op = UOP_GCD; opa = bm_ff; opb = ad_ff; end
         S_MU_Q1: begin cmd.op = UOP_DIV; opa = am_ff; opb = g_ff; end
         S_MU_Q2: begin cmd.op = UOP_DIV; opa = bd_ff; opb = g_ff; end
         S_MU_Q3: begin cmd.op = UOP_DIV; opa = bm_ff; opb = g2_ff; end
         S_MU_Q4: begin cmd.op = UOP_DIV; opa = ad_ff; opb = g2_ff; end
         S_MU_M1: begin cmd.op = UOP_MUL; opa = am_ff; opb = bm_ff; end
         S_MU_M2: begin cmd.op = UOP_MUL; opa = ad_ff; opb = bd_ff; end
         S_RR_G:  begin cmd.op = UOP_GCD; opa = rm_ff; opb = rd_ff; end
         S_RR_N:  begin cmd.op = UOP_DIV; opa = rm_ff; opb = g_ff; end
         S_RR_D:  begin cmd.op = UOP_DIV; opa = rd_ff; opb = g_ff; end
         default: begin cmd.op = UOP_GCD; end
      endcase
      if (st_ff != S_IDLE && st_ff != S_FIX && st_ff != S_SPLIT && st_ff != S_AD_S
          && st_ff != S_DONE && !iss_ff) begin
         cmd.start = 1'b1;
      end
   end

   always_comb begin
      st_in  = st_ff;
      iss_in = iss_ff;
      fn_in  = fn_ff;
      an_in  = an_ff;  am_in = am_ff;  ad_in = ad_ff;
      bn_in  = bn_ff;  bm_in = bm_ff;  bd_in = bd_ff;
      g_in   = g_ff;   g2_in = g2_ff;
      t1_in  = t1_ff;  t2_in = t2_ff;
      ov_in  = ov_ff;
      rn_in  = rn_ff;  rm_in = rm_ff;  rd_in = rd_ff;
      if (cmd.start) begin
         iss_in = 1'b1;
      end
      case (st_ff)
         S_IDLE: begin
            if (start) begin
               fn_in = func;
               an_in = a_num[WORD_BITS-1];
               am_in = a_num[WORD_BITS-1] ? ('0 - a_num) : a_num;
               ad_in = a_den;
               bn_in = b_num[WORD_BITS-1];
               bm_in = b_num[WORD_BITS-1] ? ('0 - b_num) : b_num;
               bd_in = b_den;
               ov_in = 1'b0;
               st_in = S_RA_G;
            end
         end
         S_DONE: st_in = S_IDLE;
         S_FIX: begin
            // zero denominators: magnitude collapses to 0 or 1
            if (ad_ff == '0) begin
               am_in = (am_ff != '0) ? {{(WORD_BITS-1){1'b0}}, 1'b1} : '0;
            end
            if (bd_ff == '0) begin
               bm_in = (bm_ff != '0) ? {{(WORD_BITS-1){1'b0}}, 1'b1} : '0;
            end
            if (am_in == '0) an_in = 1'b0;
            if (bm_in == '0) bn_in = 1'b0;
            if (fn_ff == FUNC_SUB && bm_in != '0) bn_in = !bn_in;
            if (fn_ff == FUNC_DIV) begin
               bd_in = bm_in;
               bm_in = bd_ff;
               if (bd_ff == '0) bn_in = 1'b0;
               if (bd_ff == '0 && bm_in == '0) bn_in = 1'b0;
            end
            st_in = (fn_ff == FUNC_ADD || fn_ff == FUNC_SUB) ? S_AD_G : S_MU_G1;
         end
         S_AD_S: begin
            t1_in = sum_w;
            if (!(t1_ff[WORD_BITS-1] ^ t2_ff[WORD_BITS-1])
                && (t1_ff[WORD_BITS-1] ^ sum_w[WORD_BITS-1])) begin
               ov_in = 1'b1;
            end
            st_in = S_AD_M3;
         end
         S_SPLIT: begin
            rn_in = t1_ff[WORD_BITS-1];
            rm_in = t1_ff[WORD_BITS-1] ? ('0 - t1_ff) : t1_ff;
            st_in = S_RR_G;
         end
         default: begin
            if (sts.done) begin
               iss_in = 1'b0;
               case (st_ff)
                  S_RA_G: begin
                     g_in  = gnz;
                     st_in = (ad_ff == '0) ? S_RB_G : S_RA_N;
                  end
                  S_RA_N:  begin am_in = u_lo; st_in = S_RA_D; end
                  S_RA_D:  begin ad_in = u_lo; st_in = S_RB_G; end
                  S_RB_G: begin
                     g_in  = gnz;
                     st_in = (bd_ff == '0) ? S_FIX : S_RB_N;
                  end
                  S_RB_N:  begin bm_in = u_lo; st_in = S_RB_D; end
                  S_RB_D:  begin bd_in = u_lo; st_in = S_FIX; end
                  S_AD_G:  begin g_in = gnz; st_in = S_AD_Q1; end
                  S_AD_Q1: begin g2_in = u_lo; st_in = S_AD_Q2; end
                  S_AD_Q2: begin t1_in = u_lo; ad_in = u_lo; st_in = S_AD_M1; end
                  S_AD_M1: begin
                     t1_in = wr_val;
                     t2_in = ad_ff;
                     if (wr_ov) ov_in = 1'b1;
                     st_in = S_AD_M2;
                  end
                  S_AD_M2: begin
                     t2_in = wr_val;
                     ad_in = t2_ff;
                     if (wr_ov) ov_in = 1'b1;
                     st_in = S_AD_S;
                  end
                  S_AD_M3: begin
                     rd_in = u_lo;
                     if (u_hi != '0) ov_in = 1'b1;
                     st_in = S_SPLIT;
                  end
                  S_MU_G1: begin g_in = gnz; st_in = S_MU_G2; end
                  S_MU_G2: begin g2_in = gnz; st_in = S_MU_Q1; end
                  S_MU_Q1: begin am_in = u_lo; st_in = S_MU_Q2; end
                  S_MU_Q2: begin bd_in = u_lo; st_in = S_MU_Q3; end
                  S_MU_Q3: begin bm_in = u_lo; st_in = S_MU_Q4; end
                  S_MU_Q4: begin ad_in = u_lo; st_in = S_MU_M1; end
                  S_MU_M1: begin
                     t1_in = wr_val;
                     if (wr_ov) ov_in = 1'b1;
                     st_in = S_MU_M2;
                  end
                  S_MU_M2: begin
                     rd_in = u_lo;
                     if (u_hi != '0) ov_in = 1'b1;
                     st_in = S_SPLIT;
                  end
                  S_RR_G: begin
                     g_in  = gnz;
                     st_in = (rd_ff == '0) ? S_DONE : S_RR_N;
                     if (rd_ff == '0) begin
                        rm_in = (rm_ff != '0) ? {{(WORD_BITS-1){1'b0}}, 1'b1} : '0;
                     end
                  end
                  S_RR_N:  begin rm_in = u_lo; st_in = S_RR_D; end
                  S_RR_D:  begin rd_in = u_lo; st_in = S_DONE; end
                  default: st_in = S_IDLE;
               endcase
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= S_IDLE;
         iss_ff <= 1'b0;
      end else begin
         st_ff  <= st_in;
         iss_ff <= iss_in;
      end
      fn_ff <= fn_in;
      an_ff <= an_in;  am_ff <= am_in;  ad_ff <= ad_in;
      bn_ff <= bn_in;  bm_ff <= bm_in;  bd_ff <= bd_in;
      g_ff  <= g_in;   g2_ff <= g2_in;
      t1_ff <= t1_in;  t2_ff <= t2_in;
      ov_ff <= ov_in;
      rn_ff <= rn_in;  rm_ff <= rm_in;  rd_ff <= rd_in;
   end

   assign busy  = (st_ff != S_IDLE);
   assign fin   = (st_ff == S_DONE);
   assign r_num = (rn_ff && rm_ff != '0) ? ('0 - rm_ff) : rm_ff;
   assign r_den = rd_ff;
   assign r_ov  = ov_ff;

endmodule

@@ hw/rtl/rfa_checker.sv @@
`include "rational_fraction_alu_top_macros.svh"

module rfa_checker (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready
);
   `RFA_ASSERT_NXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)
   `RFA_ASSERT_IMP(a_no_accept_while_rsp, clock, reset, rsp_tvalid, !req_tready)
   `RFA_ASSERT_NXT(a_rsp_holds, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
endmodule

bind rational_fraction_alu_top rfa_checker u_rfa_checker (
   .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready
);

@@ tb/rational_fraction_alu_top_test.sv @@
`timescale 1ns / 1ps

module rational_fraction_alu_top_test;
   import rfa_pkg::*;

   localparam int CYCLE_LIMIT = 100000000;
   localparam int N_RANDOM = 630;
   localparam logic [63:0] MIN_S = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MAX_S = 64'h7fff_ffff_ffff_ffff;
   localparam logic [63:0] MAX_U = 64'hffff_ffff_ffff_ffff;

   typedef struct {
      bit          neg;
      logic [63:0] mag;
      logic [63:0] den;
   } frac_type;

   typedef struct {
      logic [63:0] num;
      logic [63:0] den;
      logic        ovf;
   } quotient_type;

   typedef struct {
      logic [1:0]   func;
      logic [63:0]  a_num, a_den, b_num, b_den;
      bit           typed;
      quotient_type want;
   } stim_row_type;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [263:0]  req_tdata;  // func, a_num, a_den, b_num, b_den, pad
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [127:0]  rsp_tdata;  // res_num, res_den
   logic          rsp_tuser;  // overflow

   quotient_type pending_q[$];
   int        n_errors = 0;
   int        n_results = 0;
   int        n_sent = 0;
   int        n_ovf = 0;
   int        cycles = 0;
   int        idle_pct = 32;

   rational_fraction_alu_top DUT (.*);

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // predictor
   function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
      logic [63:0] t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return (x == 0) ? 64'd1 : x;
   endfunction

   function automatic logic [63:0] clip_signed(bit neg, logic [127:0] p, inout logic ovf);
      if (p[127:64] != 0 || p[63:0] > (neg ? MIN_S : MAX_S)) ovf = 1;
      return neg ? -p[63:0] : p[63:0];
   endfunction

   function automatic frac_type unpack_frac(logic [63:0] pat, logic [63:0] den);
      frac_type f;
      f.neg = pat[63];
      f.mag = f.neg ? -pat : pat;
      f.den = den;
      return f;
   endfunction

   function automatic frac_type reduce_frac(frac_type f);
      logic [63:0] g;
      if (f.den == 0) begin
         f.mag = (f.mag != 0) ? 64'd1 : 64'd0;
      end else begin
         g = gcd64(f.mag, f.den);
         f.mag = f.mag / g;
         f.den = f.den / g;
      end
      if (f.mag == 0) f.neg = 0;
      return f;
   endfunction

   function automatic frac_type sum_fracs(frac_type a, frac_type b, inout logic ovf);
      logic [63:0]  g, t1, t2, s;
      logic [127:0] p;
      g = gcd64(a.den, b.den);
      p = a.mag * (b.den / g);
      t1 = clip_signed(a.neg, p, ovf);
      p = b.mag * (a.den / g);
      t2 = clip_signed(b.neg, p, ovf);
      s = t1 + t2;
      if (t1[63] == t2[63] && t1[63] != s[63]) ovf = 1;
      p = (a.den / g) * b.den;
      if (p[127:64] != 0) ovf = 1;
      return reduce_frac(unpack_frac(s, p[63:0]));
   endfunction

   function automatic frac_type product_fracs(frac_type a, frac_type b, inout logic ovf);
      logic [63:0]  g1, g2, n;
      logic [127:0] p;
      g1 = gcd64(a.mag, b.den);
      g2 = gcd64(b.mag, a.den);
      p = (a.mag / g1) * (b.mag / g2);
      n = clip_signed(a.neg != b.neg, p, ovf);
      p = (a.den / g2) * (b.den / g1);
      if (p[127:64] != 0) ovf = 1;
      return reduce_frac(unpack_frac(n, p[63:0]));
   endfunction

   function automatic quotient_type predict_fraction(stim_row_type r);
      frac_type     a, b, inv, res;
      logic         ovf;
      quotient_type q;
      ovf = 0;
      a = reduce_frac(unpack_frac(r.a_num, r.a_den));
      b = reduce_frac(unpack_frac(r.b_num, r.b_den));
      case (r.func)
         FUNC_ADD: res = sum_fracs(a, b, ovf);
         FUNC_SUB: begin
            if (b.mag != 0) b.neg = !b.neg;
            res = sum_fracs(a, b, ovf);
         end
         FUNC_MUL: res = product_fracs(a, b, ovf);
         default: begin
            inv.neg = (b.den == 0) ? 1'b0 : b.neg;
            inv.mag = b.den;
            inv.den = b.mag;
            res = product_fracs(a, inv, ovf);
         end
      endcase
      q.num = res.neg ? -res.mag : res.mag;
      q.den = res.den;
      q.ovf = ovf;
      return q;
   endfunction

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      n_errors++;
      $display("mismatch on result %0d: %s got %h want %h", n_results, field, got, want);
   endtask

   task automatic send_fraction_pair(stim_row_type r);
      if ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_tvalid <= 1;
      req_tdata <= {6'd0, r.b_den, r.b_num, r.a_den, r.a_num, r.func};
      do @(posedge clock); while (!(req_tvalid && req_tready));
      pending_q.push_back(r.typed ? r.want : predict_fraction(r));
      n_sent++;
   endtask

   function automatic logic [63:0] pick_num(bit wide);
      case ($urandom_range(9))
         0: return MIN_S;
         1: return MAX_S;
         2: return 64'd0;
         default: begin
            if (wide) return {$urandom, $urandom};
            return {{48{1'b0}}, 16'($urandom)} - 64'd32768;
         end
      endcase
   endfunction

   function automatic logic [63:0] pick_den(bit wide);
      case ($urandom_range(9))
         0: return 64'd0;
         1: return MAX_U;
         2: return 64'd1;
         default: return wide ? {$urandom, $urandom} : 64'($urandom_range(65535, 1));
      endcase
   endfunction

   // result checker, also drives rsp_tready and the cycle timeout
   always @(posedge clock) begin
      quotient_type w;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout with %0d results outstanding", pending_q.size());
         $display("Verification failed");
         $finish;
      end
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= idle_pct);
         if (rsp_tvalid && rsp_tready) begin
            if (pending_q.size() == 0) begin
               n_errors++;
               $display("unexpected item on the result channel");
            end else begin
               w = pending_q.pop_front();
               if (rsp_tdata[63:0] !== w.num) report_mismatch("res_num", rsp_tdata[63:0], w.num);
               if (rsp_tdata[127:64] !== w.den)
                  report_mismatch("res_den", rsp_tdata[127:64], w.den);
               if (rsp_tuser !== w.ovf)
                  report_mismatch("overflow", 64'(rsp_tuser), 64'(w.ovf));
               if (rsp_tuser === 1'b1) n_ovf++;
            end
            n_results++;
         end
      end
   end

   stim_row_type directed_rows[] = '{
      '{FUNC_ADD, 64'd0, 64'd0, 64'd0, 64'd0, 1, '{64'd0, 64'd0, 1'b0}},
      '{FUNC_ADD, 64'd5, 64'd0, 64'd1, 64'd1, 1, '{64'd1, 64'd0, 1'b0}},
      '{FUNC_MUL, 64'd0, 64'd7, 64'd3, 64'd5, 1, '{64'd0, 64'd1, 1'b0}},
      '{FUNC_ADD, 64'd1, 64'd2, 64'd1, 64'd3, 0, '{0, 0, 0}},
      '{FUNC_SUB, 64'd1, 64'd2, 64'd1, 64'd3, 0, '{0, 0, 0}},
      '{FUNC_MUL, 64'd4, 64'd6, 64'd9, 64'd8, 0, '{0, 0, 0}},
      '{FUNC_DIV, 64'd3, 64'd4, -64'd3, 64'd8, 0, '{0, 0, 0}},
      '{FUNC_DIV, 64'd3, 64'd4, 64'd0, 64'd5, 0, '{0, 0, 0}},
      '{FUNC_DIV, -64'd7, 64'd0, 64'd2, 64'd0, 0, '{0, 0, 0}},
      '{FUNC_SUB, 64'd0, 64'd1, MIN_S, 64'd1, 0, '{0, 0, 0}},
      '{FUNC_ADD, MIN_S, 64'd1, MIN_S, 64'd1, 0, '{0, 0, 0}},
      '{FUNC_ADD, MAX_S, 64'd1, MAX_S, 64'd1, 0, '{0, 0, 0}},
      '{FUNC_MUL, MAX_S, 64'd1, MAX_S, 64'd1, 0, '{0, 0, 0}},
      '{FUNC_MUL, MIN_S, MAX_U, -64'd1, 64'd1, 0, '{0, 0, 0}},
      '{FUNC_ADD, 64'd1, MAX_U, 64'd1, MAX_U - 64'd1, 0, '{0, 0, 0}},
      '{FUNC_DIV, 64'd1, 64'd1, 64'd1, MAX_U, 0, '{0, 0, 0}},
      '{FUNC_DIV, MIN_S, 64'd3, MIN_S, MAX_U, 0, '{0, 0, 0}},
      '{FUNC_SUB, MAX_S, MAX_U, MIN_S, MAX_U, 0, '{0, 0, 0}},
      '{FUNC_MUL, 64'd12, 64'd0, 64'd0, 64'd0, 0, '{0, 0, 0}},
      '{FUNC_SUB, -64'd6, 64'd4, -64'd6, 64'd4, 0, '{0, 0, 0}}
   };

   initial begin
      stim_row_type r;
      bit           wide;
      int           drain;
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (directed_rows[i]) send_fraction_pair(directed_rows[i]);
      for (int i = 0; i < N_RANDOM; i++) begin
         idle_pct = (i >= 300 && i < 400) ? 0 : 32;
         wide = ($urandom_range(9) == 0);
         r.func = 2'($urandom);
         r.a_num = pick_num(wide);
         r.a_den = pick_den(wide);
         r.b_num = pick_num(wide);
         r.b_den = pick_den(wide);
         r.typed = 0;
         send_fraction_pair(r);
      end
      req_tvalid <= 0;
      while (pending_q.size() != 0) @(posedge clock);
      drain = 0;
      while (drain < 100) begin
         @(posedge clock);
         drain++;
      end
      $display("%0d fraction pairs sent over all four operations, %0d results checked",
               n_sent, n_results);
      $display("%0d results flagged overflow, %0d mismatches", n_ovf, n_errors);
      if (n_errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
